// ===== src/ddo_pkg.sv =====
// Shared types, constants and helper functions for the differential-drive odometry block.
// Depends on nothing; every other file of the block uses it except ddo_checker.
`default_nettype none
package ddo_pkg;

   localparam int DDO_COUNT_BITS    = 32;
   localparam int DDO_POS_FRAC_BITS = 16;
   localparam int DDO_ANGLE_BITS    = 16;

   localparam int POS_W   = 32;
   localparam int HEAD_W  = 16;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CFG_INITIAL_X       = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_INITIAL_Y       = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_INITIAL_HEADING = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_LINEAR_ADJUST   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_ANGULAR_ADJUST  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_WHEEL_RADIUS    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CFG_WHEEL_BASE      = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CFG_TICKS_PER_TURN  = 4'd7;

   localparam logic [15:0] RADIUS_RESET = 16'd3198;
   localparam logic [17:0] BASE_RESET   = 18'd14241;
   localparam logic [31:0] TICKS_RESET  = 32'd58848707;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam logic [63:0] MAG_LIM = 64'd1 << 62;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] q;
   } md_rsp_type;

   function automatic logic [63:0] sat_mag(input logic [63:0] m);
      return (m > MAG_LIM) ? MAG_LIM : m;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Series term divisors (k times 2^30) for the sine and cosine steps.
   function automatic logic [63:0] term_div(input logic [3:0] step);
      logic [63:0] k;
      case (step)
         4'd2:    k = 64'd6;
         4'd3:    k = 64'd20;
         4'd4:    k = 64'd42;
         4'd5:    k = 64'd72;
         4'd6:    k = 64'd110;
         4'd7:    k = 64'd2;
         4'd8:    k = 64'd12;
         4'd9:    k = 64'd30;
         4'd10:   k = 64'd56;
         4'd11:   k = 64'd90;
         4'd12:   k = 64'd132;
         default: k = 64'd1;
      endcase
      return k << 30;
   endfunction

endpackage
`default_nettype wire

// ===== src/ddo_req_if.sv =====
// Input channel of the odometry block: valid, ready and the two encoder counts.
// Depends on ddo_pkg for the field widths.
`default_nettype none
interface ddo_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ddo_pkg::POS_W-1:0]     left_count;
   logic signed [ddo_pkg::POS_W-1:0]     right_count;
   modport source (output valid, left_count, right_count, input ready);
   modport sink   (input valid, left_count, right_count, output ready);
endinterface
`default_nettype wire

// ===== src/ddo_rsp_if.sv =====
// Result channel of the odometry block: valid, ready and both pose estimates.
// Depends on ddo_pkg for the field widths.
`default_nettype none
interface ddo_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ddo_pkg::POS_W-1:0]     euler_x;
   logic signed [ddo_pkg::POS_W-1:0]     euler_y;
   logic        [ddo_pkg::HEAD_W-1:0]    euler_heading;
   logic signed [ddo_pkg::POS_W-1:0]     arc_x;
   logic signed [ddo_pkg::POS_W-1:0]     arc_y;
   logic        [ddo_pkg::HEAD_W-1:0]    arc_heading;
   modport source (output valid, euler_x, euler_y, euler_heading, arc_x, arc_y,
                   arc_heading, input ready);
   modport sink   (input valid, euler_x, euler_y, euler_heading, arc_x, arc_y,
                   arc_heading, output ready);
endinterface
`default_nettype wire

// ===== src/ddo_muldiv.sv =====
// Shared multiply-divide unit: floor(a*b/c) with an exact 128-bit product, saturating
// to all ones when the quotient does not fit. Depends on ddo_pkg.
`default_nettype none
module ddo_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  ddo_pkg::md_req_type md_req,
   output ddo_pkg::md_rsp_type md_rsp
);
   import ddo_pkg::*;

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_MUL  = 3'd1;
   localparam logic [2:0] M_CHK  = 3'd2;
   localparam logic [2:0] M_DIV  = 3'd3;
   localparam logic [2:0] M_DONE = 3'd4;

   logic [2:0]  st_ff, st_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in, c_ff, c_in, hi_ff, hi_in, lo_ff, lo_in;
   logic [64:0] acc;
   logic [63:0] sh;
   logic        ge;

   always_comb begin
      st_in  = st_ff;
      cnt_in = cnt_ff;
      a_in   = a_ff;
      c_in   = c_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      acc    = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : 65'd0);
      sh     = {hi_ff[62:0], lo_ff[63]};
      ge     = hi_ff[63] || (sh >= c_ff);
      unique case (st_ff)
         M_IDLE: begin
            if (md_req.start) begin
               a_in   = md_req.a;
               c_in   = md_req.c;
               hi_in  = 64'd0;
               lo_in  = md_req.b;
               cnt_in = 6'd0;
               st_in  = M_MUL;
            end
         end
         M_MUL: begin
            hi_in  = acc[64:1];
            lo_in  = {acc[0], lo_ff[63:1]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               st_in = M_CHK;
            end
         end
         M_CHK: begin
            cnt_in = 6'd0;
            if (hi_ff >= c_ff) begin
               lo_in = '1;
               st_in = M_DONE;
            end else begin
               st_in = M_DIV;
            end
         end
         M_DIV: begin
            hi_in  = ge ? (sh - c_ff) : sh;
            lo_in  = {lo_ff[62:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               st_in = M_DONE;
            end
         end
         M_DONE: begin
            st_in = M_IDLE;
         end
         default: begin
            st_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= M_IDLE;
      end else begin
         st_ff <= st_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      c_ff   <= c_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   assign md_rsp.done = (st_ff == M_DONE);
   assign md_rsp.q    = lo_ff;

endmodule
`default_nettype wire

// ===== src/diff_drive_odometry.sv =====
// Top level of the differential-drive odometry block: sequencer, state and configuration.
// Depends on ddo_pkg, ddo_req_if, ddo_rsp_if and ddo_muldiv.
//
//   channel   | direction | transfer when          | content
//   req_chan  | in        | valid && ready         | left_count, right_count
//   rsp_chan  | out       | valid && ready         | euler x/y/heading, arc x/y/heading
//   csr_*     | in        | csr_we                 | register index and write data
//
// An update with a turn runs up to 53 multiply-divide operations on the shared unit, each an
// issue, 64 multiply steps, a range check, 64 divide steps (skipped when the quotient
// saturates) and a handoff, plus a quadrant step after each of three sine and cosine series.
// A straight move needs 38 operations.
// Reset is synchronous; it restores the register defaults and clears both poses.
// The input is not ready from acceptance until the result transfer completes.
// A stalled result holds its value while ready stays low, unless a register write changes an initial pose.
`default_nettype none
module diff_drive_odometry #(
   parameter int COUNT_BITS    = ddo_pkg::DDO_COUNT_BITS,
   parameter int POS_FRAC_BITS = ddo_pkg::DDO_POS_FRAC_BITS,
   parameter int ANGLE_BITS    = ddo_pkg::DDO_ANGLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   ddo_req_if.sink                             req_chan,
   ddo_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [ddo_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ddo_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ddo_pkg::*;

   localparam int CB = COUNT_BITS;
   localparam int AB = ANGLE_BITS;
   localparam int SH_UP = (POS_FRAC_BITS >= 16) ? POS_FRAC_BITS - 16 : 0;
   localparam int SH_DN = (POS_FRAC_BITS < 16) ? 16 - POS_FRAC_BITS : 0;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_OP       = 3'd1;
   localparam logic [2:0] S_WAIT     = 3'd2;
   localparam logic [2:0] S_TRIG_END = 3'd3;
   localparam logic [2:0] S_OUT      = 3'd4;

   localparam logic [4:0] P_RS    = 5'd0;
   localparam logic [4:0] P_RD    = 5'd1;
   localparam logic [4:0] P_TB    = 5'd2;
   localparam logic [4:0] P_TRAV  = 5'd3;
   localparam logic [4:0] P_TURN  = 5'd4;
   localparam logic [4:0] P_LE    = 5'd5;
   localparam logic [4:0] P_ESC   = 5'd6;
   localparam logic [4:0] P_EX    = 5'd7;
   localparam logic [4:0] P_EY    = 5'd8;
   localparam logic [4:0] P_EA    = 5'd9;
   localparam logic [4:0] P_TP    = 5'd10;
   localparam logic [4:0] P_HSC   = 5'd11;
   localparam logic [4:0] P_CHORD = 5'd12;
   localparam logic [4:0] P_PSC   = 5'd13;
   localparam logic [4:0] P_AX    = 5'd14;
   localparam logic [4:0] P_AY    = 5'd15;
   localparam logic [4:0] P_ADJ   = 5'd16;

   function automatic logic signed [63:0] q16_to_pos(input logic signed [31:0] v);
      logic [31:0] mg;
      logic [63:0] m;
      mg = v[31] ? (~v + 32'd1) : v;
      m  = (64'(mg) << SH_UP) >> SH_DN;
      return v[31] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [31:0] add_pos(input logic signed [31:0] base,
                                                  input logic [63:0] m, input logic neg);
      logic signed [63:0] d, b;
      d = $signed(sat_mag(m));
      b = {{32{base[31]}}, base};
      return sat32(neg ? (b - d) : (b + d));
   endfunction

   md_req_type md_req;
   md_rsp_type md_rsp;
   logic       md_start;

   ddo_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   logic [2:0]  state_ff, state_in;
   logic [4:0]  pc_ff, pc_in;
   logic [3:0]  sk_ff, sk_in;

   logic signed [31:0] lin_adj_ff, lin_adj_in, ang_adj_ff, ang_adj_in;
   logic [15:0] rad_ff, rad_in;
   logic [17:0] base_ff, base_in;
   logic [31:0] tpt_ff, tpt_in;

   logic [CB-1:0] last_left_ff, last_left_in, last_right_ff, last_right_in;
   logic signed [31:0] ex_ff, ex_in, ey_ff, ey_in, ax_ff, ax_in, ay_ff, ay_in;
   logic [AB-1:0] euler_ang_ff, euler_ang_in, arc_ang_ff, arc_ang_in;

   logic [CB:0] mag_sum_ff, mag_sum_in, mag_dif_ff, mag_dif_in;
   logic        sum_neg_ff, sum_neg_in, dif_neg_ff, dif_neg_in;
   logic [63:0] rs_ff, rs_in, rd_ff, rd_in, tb_ff, tb_in, trav_ff, trav_in;
   logic [63:0] turn_ff, turn_in, le_ff, le_in, tp_ff, tp_in, chord_ff, chord_in;
   logic [31:0] x_ff, x_in, x2_ff, x2_in, t_ff, t_in;
   logic signed [32:0] s0_ff, s0_in, c0_ff, c0_in;
   logic [31:0] sin_mag_ff, sin_mag_in, cos_mag_ff, cos_mag_in;
   logic        sin_neg_ff, sin_neg_in, cos_neg_ff, cos_neg_in, cn_ff, cn_in;
   logic [AB:0] h_ff, h_in;

   logic signed [CB-1:0] dl_c, dr_c;
   logic signed [CB+1:0] sum_c, dif_c;
   logic signed [33:0]   fl_c, fa_c;
   logic [33:0]  fl_mag, fa_mag;
   logic [31:0]  aa_mag;
   logic [31:0]  tpt0;
   logic [17:0]  base0;
   logic [AB:0]  ang_c;
   logic         wide_c, swap_c;
   logic [AB-2:0] r_c;
   logic [1:0]   quad_c;
   logic [AB-1:0] quarter_c, rp_c;
   logic [63:0]  xdiv_c;
   logic [31:0]  qt;
   logic signed [33:0] sv_c, cv_c, ts_c, tc_c;
   logic [AB-1:0] acc1_c;
   logic signed [63:0] la_pos;

   always_comb begin
      dl_c  = req_chan.left_count[CB-1:0] - last_left_ff;
      dr_c  = req_chan.right_count[CB-1:0] - last_right_ff;
      sum_c = $signed({{2{dl_c[CB-1]}}, dl_c}) - $signed({{2{dr_c[CB-1]}}, dr_c});
      dif_c = -$signed({{2{dr_c[CB-1]}}, dr_c}) - $signed({{2{dl_c[CB-1]}}, dl_c});
      fl_c  = $signed({{2{lin_adj_ff[31]}}, lin_adj_ff}) + 34'sd65536;
      fa_c  = $signed({{2{ang_adj_ff[31]}}, ang_adj_ff}) + 34'sd65536;
      fl_mag = fl_c[33] ? 34'(-fl_c) : 34'(fl_c);
      fa_mag = fa_c[33] ? 34'(-fa_c) : 34'(fa_c);
      aa_mag = ang_adj_ff[31] ? (~ang_adj_ff + 32'd1) : ang_adj_ff;
      tpt0   = (tpt_ff == 32'd0) ? 32'd1 : tpt_ff;
      base0  = (base_ff == 18'd0) ? 18'd1 : base_ff;
      la_pos = q16_to_pos(lin_adj_ff);
      qt     = md_rsp.q[31:0];

      unique case (pc_ff)
         P_ESC: begin
            ang_c  = {1'b0, euler_ang_ff};
            wide_c = 1'b0;
         end
         P_HSC: begin
            ang_c  = h_ff;
            wide_c = 1'b1;
         end
         default: begin
            ang_c  = {arc_ang_ff, 1'b0} + h_ff;
            wide_c = 1'b1;
         end
      endcase
      if (wide_c) begin
         r_c       = ang_c[AB-2:0];
         quad_c    = ang_c[AB:AB-1];
         quarter_c = AB'(1) << (AB - 1);
         xdiv_c    = 64'd1 << AB;
      end else begin
         r_c       = {1'b0, ang_c[AB-3:0]};
         quad_c    = ang_c[AB-1:AB-2];
         quarter_c = AB'(1) << (AB - 2);
         xdiv_c    = 64'd1 << (AB - 1);
      end
      swap_c = {1'b0, r_c} > (quarter_c >> 1);
      rp_c   = swap_c ? (quarter_c - {1'b0, r_c}) : {1'b0, r_c};

      sv_c = swap_c ? 34'(c0_ff) : 34'(s0_ff);
      cv_c = swap_c ? 34'(s0_ff) : 34'(c0_ff);
      case (quad_c)
         2'd0: begin ts_c = sv_c;  tc_c = cv_c;  end
         2'd1: begin ts_c = cv_c;  tc_c = -sv_c; end
         2'd2: begin ts_c = -sv_c; tc_c = -cv_c; end
         default: begin ts_c = -cv_c; tc_c = sv_c; end
      endcase

      acc1_c = dif_neg_ff ? (arc_ang_ff - turn_ff[AB-1:0]) : (arc_ang_ff + turn_ff[AB-1:0]);
   end

   always_comb begin
      md_req.start = md_start;
      md_req.a = 64'd0;
      md_req.b = 64'd0;
      md_req.c = 64'd1;
      unique case (pc_ff)
         P_RS: begin
            md_req.a = 64'(rad_ff);
            md_req.b = 64'(mag_sum_ff);
         end
         P_RD: begin
            md_req.a = 64'(rad_ff);
            md_req.b = 64'(mag_dif_ff);
         end
         P_TB: begin
            md_req.a = 64'(tpt0);
            md_req.b = 64'(base0);
         end
         P_TRAV: begin
            md_req.a = rs_ff;
            md_req.b = PI_Q30 << POS_FRAC_BITS;
            md_req.c = 64'(tpt0) << 30;
         end
         P_TURN: begin
            md_req.a = rd_ff;
            md_req.b = 64'd1 << (16 + AB);
            md_req.c = tb_ff;
         end
         P_LE: begin
            md_req.a = trav_ff;
            md_req.b = 64'(fl_mag);
            md_req.c = 64'd65536;
         end
         P_ESC, P_HSC, P_PSC: begin
            case (sk_ff)
               4'd0: begin
                  md_req.a = 64'(rp_c);
                  md_req.b = PI_Q30;
                  md_req.c = xdiv_c;
               end
               4'd1: begin
                  md_req.a = 64'(x_ff);
                  md_req.b = 64'(x_ff);
                  md_req.c = ONE_Q30;
               end
               default: begin
                  md_req.a = 64'(t_ff);
                  md_req.b = 64'(x2_ff);
                  md_req.c = term_div(sk_ff);
               end
            endcase
         end
         P_EX, P_AX: begin
            md_req.a = (pc_ff == P_EX) ? le_ff : chord_ff;
            md_req.b = 64'(cos_mag_ff);
            md_req.c = ONE_Q30;
         end
         P_EY, P_AY: begin
            md_req.a = (pc_ff == P_EY) ? le_ff : chord_ff;
            md_req.b = 64'(sin_mag_ff);
            md_req.c = ONE_Q30;
         end
         P_EA: begin
            md_req.a = rd_ff;
            md_req.b = 64'(fa_mag) << AB;
            md_req.c = tb_ff;
         end
         P_TP: begin
            md_req.a = turn_ff;
            md_req.b = PI_Q30;
         end
         P_CHORD: begin
            md_req.a = trav_ff;
            md_req.b = 64'(sin_mag_ff) << AB;
            md_req.c = tp_ff;
         end
         P_ADJ: begin
            md_req.a = 64'(aa_mag);
            md_req.b = 64'd1 << (AB + 13);
            md_req.c = PI_Q30;
         end
         default: begin
            md_req.a = 64'd0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;      pc_in = pc_ff;            sk_in = sk_ff;
      lin_adj_in = lin_adj_ff;  ang_adj_in = ang_adj_ff;
      rad_in = rad_ff;          base_in = base_ff;        tpt_in = tpt_ff;
      last_left_in = last_left_ff;  last_right_in = last_right_ff;
      ex_in = ex_ff;  ey_in = ey_ff;  ax_in = ax_ff;  ay_in = ay_ff;
      euler_ang_in = euler_ang_ff;  arc_ang_in = arc_ang_ff;
      mag_sum_in = mag_sum_ff;  mag_dif_in = mag_dif_ff;
      sum_neg_in = sum_neg_ff;  dif_neg_in = dif_neg_ff;
      rs_in = rs_ff;  rd_in = rd_ff;  tb_in = tb_ff;  trav_in = trav_ff;
      turn_in = turn_ff;  le_in = le_ff;  tp_in = tp_ff;  chord_in = chord_ff;
      x_in = x_ff;  x2_in = x2_ff;  t_in = t_ff;  s0_in = s0_ff;  c0_in = c0_ff;
      sin_mag_in = sin_mag_ff;  cos_mag_in = cos_mag_ff;
      sin_neg_in = sin_neg_ff;  cos_neg_in = cos_neg_ff;  cn_in = cn_ff;  h_in = h_ff;
      md_start = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               last_left_in  = req_chan.left_count[CB-1:0];
               last_right_in = req_chan.right_count[CB-1:0];
               mag_sum_in    = sum_c[CB+1] ? (CB+1)'(-sum_c) : (CB+1)'(sum_c);
               mag_dif_in    = dif_c[CB+1] ? (CB+1)'(-dif_c) : (CB+1)'(dif_c);
               sum_neg_in    = sum_c[CB+1];
               dif_neg_in    = dif_c[CB+1];
               pc_in         = P_RS;
               sk_in         = 4'd0;
               state_in      = S_OP;
            end
         end
         S_OP: begin
            md_start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (md_rsp.done) begin
               state_in = S_OP;
               unique case (pc_ff)
                  P_RS:   begin rs_in = md_rsp.q; pc_in = P_RD; end
                  P_RD:   begin rd_in = md_rsp.q; pc_in = P_TB; end
                  P_TB:   begin tb_in = md_rsp.q; pc_in = P_TRAV; end
                  P_TRAV: begin trav_in = sat_mag(md_rsp.q); pc_in = P_TURN; end
                  P_TURN: begin turn_in = sat_mag(md_rsp.q); pc_in = P_LE; end
                  P_LE: begin
                     le_in = sat_mag(md_rsp.q);
                     pc_in = P_ESC;
                     sk_in = 4'd0;
                  end
                  P_ESC, P_HSC, P_PSC: begin
                     sk_in = sk_ff + 4'd1;
                     if (sk_ff == 4'd0) begin
                        x_in  = qt;
                        t_in  = qt;
                        s0_in = $signed({1'b0, qt});
                        c0_in = $signed({1'b0, ONE_Q30[31:0]});
                     end else if (sk_ff == 4'd1) begin
                        x2_in = qt;
                     end else if (sk_ff <= 4'd6) begin
                        t_in  = (sk_ff == 4'd6) ? ONE_Q30[31:0] : qt;
                        s0_in = sk_ff[0] ? (s0_ff + $signed({1'b0, qt}))
                                         : (s0_ff - $signed({1'b0, qt}));
                     end else begin
                        t_in  = qt;
                        c0_in = sk_ff[0] ? (c0_ff - $signed({1'b0, qt}))
                                         : (c0_ff + $signed({1'b0, qt}));
                        if (sk_ff == 4'd12) begin
                           state_in = S_TRIG_END;
                        end
                     end
                  end
                  P_EX: begin
                     ex_in = add_pos(ex_ff, md_rsp.q, sum_neg_ff ^ fl_c[33] ^ cos_neg_ff);
                     pc_in = P_EY;
                  end
                  P_EY: begin
                     ey_in = add_pos(ey_ff, md_rsp.q, sum_neg_ff ^ fl_c[33] ^ sin_neg_ff);
                     pc_in = P_EA;
                  end
                  P_EA: begin
                     euler_ang_in = (dif_neg_ff ^ fa_c[33])
                                  ? (euler_ang_ff - md_rsp.q[AB-1:0])
                                  : (euler_ang_ff + md_rsp.q[AB-1:0]);
                     if (turn_ff == 64'd0) begin
                        chord_in = trav_ff;
                        cn_in    = sum_neg_ff;
                        h_in     = '0;
                        pc_in    = P_PSC;
                        sk_in    = 4'd0;
                     end else begin
                        h_in  = dif_neg_ff ? (AB+1)'(-turn_ff[AB:0]) : turn_ff[AB:0];
                        pc_in = P_TP;
                     end
                  end
                  P_TP: begin
                     tp_in = md_rsp.q;
                     pc_in = P_HSC;
                     sk_in = 4'd0;
                  end
                  P_CHORD: begin
                     chord_in = sat_mag(md_rsp.q);
                     pc_in    = P_PSC;
                     sk_in    = 4'd0;
                  end
                  P_AX: begin
                     ax_in = add_pos(ax_ff, md_rsp.q, cn_ff ^ cos_neg_ff);
                     pc_in = P_AY;
                  end
                  P_AY: begin
                     ay_in = add_pos(ay_ff, md_rsp.q, cn_ff ^ sin_neg_ff);
                     pc_in = P_ADJ;
                  end
                  P_ADJ: begin
                     arc_ang_in = ang_adj_ff[31] ? (acc1_c - md_rsp.q[AB-1:0])
                                                 : (acc1_c + md_rsp.q[AB-1:0]);
                     ax_in    = sat32({{32{ax_ff[31]}}, ax_ff} + la_pos);
                     ay_in    = sat32({{32{ay_ff[31]}}, ay_ff} + la_pos);
                     state_in = S_OUT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_TRIG_END: begin
            sin_neg_in = ts_c[33];
            cos_neg_in = tc_c[33];
            sin_mag_in = ts_c[33] ? 32'(-ts_c) : 32'(ts_c);
            cos_mag_in = tc_c[33] ? 32'(-tc_c) : 32'(tc_c);
            state_in   = S_OP;
            unique case (pc_ff)
               P_ESC: pc_in = P_EX;
               P_HSC: begin
                  cn_in = sum_neg_ff ^ ts_c[33] ^ dif_neg_ff;
                  sk_in = 4'd0;
                  if (turn_ff[63:32] != 32'd0) begin
                     chord_in = 64'd0;
                     pc_in    = P_PSC;
                  end else begin
                     pc_in = P_CHORD;
                  end
               end
               default: pc_in = P_AX;
            endcase
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CFG_INITIAL_X: begin
               ex_in = sat32(q16_to_pos(csr_wdata));
               ax_in = sat32(q16_to_pos(csr_wdata));
            end
            CFG_INITIAL_Y: begin
               ey_in = sat32(q16_to_pos(csr_wdata));
               ay_in = sat32(q16_to_pos(csr_wdata));
            end
            CFG_INITIAL_HEADING: begin
               euler_ang_in = AB'(csr_wdata[15:0]);
               arc_ang_in   = AB'(csr_wdata[15:0]);
            end
            CFG_LINEAR_ADJUST:  lin_adj_in = csr_wdata;
            CFG_ANGULAR_ADJUST: ang_adj_in = csr_wdata;
            CFG_WHEEL_RADIUS:   rad_in = csr_wdata[15:0];
            CFG_WHEEL_BASE:     base_in = csr_wdata[17:0];
            CFG_TICKS_PER_TURN: tpt_in = csr_wdata;
            default: begin
               rad_in = rad_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pc_ff         <= P_RS;
         sk_ff         <= 4'd0;
         lin_adj_ff    <= '0;
         ang_adj_ff    <= '0;
         rad_ff        <= RADIUS_RESET;
         base_ff       <= BASE_RESET;
         tpt_ff        <= TICKS_RESET;
         last_left_ff  <= '0;
         last_right_ff <= '0;
         ex_ff         <= '0;
         ey_ff         <= '0;
         ax_ff         <= '0;
         ay_ff         <= '0;
         euler_ang_ff  <= '0;
         arc_ang_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         sk_ff         <= sk_in;
         lin_adj_ff    <= lin_adj_in;
         ang_adj_ff    <= ang_adj_in;
         rad_ff        <= rad_in;
         base_ff       <= base_in;
         tpt_ff        <= tpt_in;
         last_left_ff  <= last_left_in;
         last_right_ff <= last_right_in;
         ex_ff         <= ex_in;
         ey_ff         <= ey_in;
         ax_ff         <= ax_in;
         ay_ff         <= ay_in;
         euler_ang_ff  <= euler_ang_in;
         arc_ang_ff    <= arc_ang_in;
      end
      mag_sum_ff <= mag_sum_in;
      mag_dif_ff <= mag_dif_in;
      sum_neg_ff <= sum_neg_in;
      dif_neg_ff <= dif_neg_in;
      rs_ff      <= rs_in;
      rd_ff      <= rd_in;
      tb_ff      <= tb_in;
      trav_ff    <= trav_in;
      turn_ff    <= turn_in;
      le_ff      <= le_in;
      tp_ff      <= tp_in;
      chord_ff   <= chord_in;
      x_ff       <= x_in;
      x2_ff      <= x2_in;
      t_ff       <= t_in;
      s0_ff      <= s0_in;
      c0_ff      <= c0_in;
      sin_mag_ff <= sin_mag_in;
      cos_mag_ff <= cos_mag_in;
      sin_neg_ff <= sin_neg_in;
      cos_neg_ff <= cos_neg_in;
      cn_ff      <= cn_in;
      h_ff       <= h_in;
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = (state_ff == S_OUT);
   assign rsp_chan.euler_x       = ex_ff;
   assign rsp_chan.euler_y       = ey_ff;
   assign rsp_chan.euler_heading = HEAD_W'(euler_ang_ff);
   assign rsp_chan.arc_x         = ax_ff;
   assign rsp_chan.arc_y         = ay_ff;
   assign rsp_chan.arc_heading   = HEAD_W'(arc_ang_ff);

endmodule
`default_nettype wire

// ===== src/ddo_checker.sv =====
// Port-level checks of the odometry block and the bind that attaches them to the top level.
// Depends on diff_drive_odometry and its channel interfaces.
`default_nettype none
module ddo_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_euler_x
);

   // A result waiting for its transfer blocks new input.
   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result is pending");

   // An accepted update does not produce its result at once and blocks further input.
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!rsp_valid && !req_ready))
      else $error("accepted update did not occupy the block");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_euler_x)))
      else $error("stalled result changed or dropped");

   a_after_reset: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_euler_x (rsp_chan.euler_x)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for diff_drive_odometry: drives encoder count updates and
// register writes, predicts both pose estimates in fixed point and checks every result.
// Depends on ddo_pkg, ddo_req_if, ddo_rsp_if and the block's RTL.
`timescale 1ns / 100ps
module tb;
   import ddo_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CFG_UNUSED_LOW  = 4'd8;
   localparam logic [CSR_IDX_W-1:0] CFG_UNUSED_HIGH = 4'd15;
   localparam longint CYCLE_LIMIT = 64'd60_000_000;

   typedef struct {
      logic [31:0] euler_x;
      logic [31:0] euler_y;
      logic [15:0] euler_heading;
      logic [31:0] arc_x;
      logic [31:0] arc_y;
      logic [15:0] arc_heading;
   } pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ddo_req_if req_chan ();
   ddo_rsp_if rsp_chan ();

   diff_drive_odometry dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   pose_type pose_q[$];
   int mismatches = 0;
   longint cycles = 0;
   bit idle_on = 1'b1;
   bit hold_off = 1'b0;

   // Predictor state.
   logic [63:0] regs [8];
   logic [31:0] prev_left, prev_right;
   longint e_x, e_y, a_x, a_y;
   logic [63:0] e_ang, a_ang;
   logic [31:0] cur_left, cur_right;

   function automatic logic [63:0] mul_div(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] c);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if (c == 0 || p[127:64] >= c) return '1;
      return 64'(p / {64'd0, c});
   endfunction

   function automatic logic [63:0] clip(input logic [63:0] m);
      return (m > MAG_LIM) ? MAG_LIM : m;
   endfunction

   function automatic logic [63:0] mabs(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint move_pos(input longint pos, input logic [63:0] m, input bit neg);
      longint d;
      d = longint'(clip(m));
      return clamp32(neg ? pos - d : pos + d);
   endfunction

   function automatic logic [63:0] turn_wrap(input logic [63:0] z, input logic [63:0] m,
                                             input bit neg);
      m = m & 64'hFFFF;
      return (neg ? z - m : z + m) & 64'hFFFF;
   endfunction

   function automatic void trig_q30(input logic [63:0] ang, input int bits,
                                    output longint sn, output longint cs);
      logic [63:0] quarter, r, q, x, x2, t;
      longint s0, c0, tmp;
      bit swap;
      quarter = 64'd1 << (bits - 2);
      r = ang & (quarter - 1);
      q = (ang >> (bits - 2)) & 64'd3;
      swap = r > (quarter >> 1);
      if (swap) r = quarter - r;
      x = (r * PI_Q30) >> (bits - 1);
      x2 = (x * x) >> 30;
      t = x;
      s0 = longint'(x);
      for (int k = 1; k <= 5; k++) begin
         t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         s0 += (k & 1) ? -longint'(t) : longint'(t);
      end
      t = ONE_Q30;
      c0 = longint'(ONE_Q30);
      for (int k = 1; k <= 6; k++) begin
         t = ((t * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
         c0 += (k & 1) ? -longint'(t) : longint'(t);
      end
      if (swap) begin
         tmp = s0; s0 = c0; c0 = tmp;
      end
      case (q)
         64'd0: begin sn = s0; cs = c0; end
         64'd1: begin sn = c0; cs = -s0; end
         64'd2: begin sn = -s0; cs = -c0; end
         default: begin sn = -c0; cs = s0; end
      endcase
   endfunction

   function automatic void odo_reset();
      regs = '{0, 0, 0, 0, 0, 64'(RADIUS_RESET), 64'(BASE_RESET), 64'(TICKS_RESET)};
      prev_left = 0; prev_right = 0;
      e_x = 0; e_y = 0; a_x = 0; a_y = 0; e_ang = 0; a_ang = 0;
   endfunction

   function automatic void odo_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] d);
      case (idx)
         CFG_INITIAL_X: begin
            regs[0] = d; e_x = longint'(signed'(d)); a_x = e_x;
         end
         CFG_INITIAL_Y: begin
            regs[1] = d; e_y = longint'(signed'(d)); a_y = e_y;
         end
         CFG_INITIAL_HEADING: begin
            regs[2] = d[15:0]; e_ang = d[15:0]; a_ang = d[15:0];
         end
         CFG_LINEAR_ADJUST:  regs[3] = d;
         CFG_ANGULAR_ADJUST: regs[4] = d;
         CFG_WHEEL_RADIUS:   regs[5] = d[15:0];
         CFG_WHEEL_BASE:     regs[6] = d[17:0];
         CFG_TICKS_PER_TURN: regs[7] = d;
         default: ;
      endcase
   endfunction

   // Works out the pose pair that one count update leads to.
   function automatic pose_type odo_advance(input logic [31:0] l, input logic [31:0] r);
      logic [31:0] dlw, drw;
      longint dl, dr, sum, dif, la, aa, fl, fa, sn, cs, hs, hc;
      logic [63:0] rad, tpt, base, trav, turn, le, ea, chord, phase, adj, h;
      bit s_neg, d_neg, c_neg;
      pose_type p;
      dlw = l - prev_left;
      drw = r - prev_right;
      dl = longint'(signed'(dlw));
      dr = longint'(signed'(drw));
      sum = dl - dr;
      dif = -dr - dl;
      la = longint'(signed'(regs[3][31:0]));
      aa = longint'(signed'(regs[4][31:0]));
      fl = 65536 + la;
      fa = 65536 + aa;
      rad = regs[5];
      tpt = (regs[7] != 0) ? regs[7] : 64'd1;
      base = (regs[6] != 0) ? regs[6] : 64'd1;
      s_neg = sum < 0;
      d_neg = dif < 0;
      prev_left = l;
      prev_right = r;
      trav = clip(mul_div(rad * mabs(sum), PI_Q30 << 16, tpt << 30));
      turn = clip(mul_div(rad * mabs(dif), 64'd1 << 32, tpt * base));

      le = clip(mul_div(trav, mabs(fl), 64'd65536));
      trig_q30(e_ang, 16, sn, cs);
      e_x = move_pos(e_x, mul_div(le, mabs(cs), ONE_Q30), s_neg ^ (fl < 0) ^ (cs < 0));
      e_y = move_pos(e_y, mul_div(le, mabs(sn), ONE_Q30), s_neg ^ (fl < 0) ^ (sn < 0));
      ea = mul_div(rad * mabs(dif), mabs(fa) << 16, tpt * base);
      e_ang = turn_wrap(e_ang, ea, d_neg ^ (fa < 0));

      if (turn == 0) begin
         chord = trav;
         c_neg = s_neg;
         phase = (a_ang << 1) & 64'h1FFFF;
      end else begin
         h = d_neg ? (64'd0 - turn) & 64'h1FFFF : turn & 64'h1FFFF;
         trig_q30(h, 17, hs, hc);
         if (turn >= (64'd1 << 32)) chord = 0;
         else chord = clip(mul_div(trav, mabs(hs) << 16, turn * PI_Q30));
         c_neg = s_neg ^ (hs < 0) ^ d_neg;
         phase = ((a_ang << 1) + h) & 64'h1FFFF;
      end
      trig_q30(phase, 17, sn, cs);
      a_x = move_pos(a_x, mul_div(chord, mabs(cs), ONE_Q30), c_neg ^ (cs < 0));
      a_y = move_pos(a_y, mul_div(chord, mabs(sn), ONE_Q30), c_neg ^ (sn < 0));
      a_ang = turn_wrap(a_ang, turn, d_neg);
      adj = mul_div(mabs(aa), 64'd1 << 29, PI_Q30);
      a_ang = turn_wrap(a_ang, adj, aa < 0);
      a_x = clamp32(a_x + la);
      a_y = clamp32(a_y + la);

      p.euler_x = e_x[31:0];
      p.euler_y = e_y[31:0];
      p.euler_heading = e_ang[15:0];
      p.arc_x = a_x[31:0];
      p.arc_y = a_y[31:0];
      p.arc_heading = a_ang[15:0];
      return p;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch at cycle %0d: %s got %h expected %h", cycles, field, got, want);
   endtask

   // Sends one count update; returns at the edge of its transfer with valid still high.
   task automatic send_counts(input logic [31:0] l, input logic [31:0] r);
      pose_type next_pose;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.left_count <= l;
      req_chan.right_count <= r;
      next_pose = odo_advance(l, r);
      pose_q = {pose_q, next_pose};
      cur_left = l;
      cur_right = r;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pose_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] d);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      odo_write(idx, d);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_defaults();
      write_reg(CFG_INITIAL_X, 32'd0);
      write_reg(CFG_INITIAL_Y, 32'd0);
      write_reg(CFG_INITIAL_HEADING, 32'd0);
      write_reg(CFG_LINEAR_ADJUST, 32'd0);
      write_reg(CFG_ANGULAR_ADJUST, 32'd0);
      write_reg(CFG_WHEEL_RADIUS, 32'(RADIUS_RESET));
      write_reg(CFG_WHEEL_BASE, 32'(BASE_RESET));
      write_reg(CFG_TICKS_PER_TURN, TICKS_RESET);
   endtask

   task automatic send_move(input int step_l, input int step_r);
      send_counts(cur_left + 32'(step_l), cur_right + 32'(step_r));
   endtask

   task automatic test_directed_moves();
      send_move(0, 0);
      send_move(300, -300);
      send_move(-300, 300);
      send_move(200, 200);
      send_move(-500, -500);
      send_move(150, -90);
      send_counts(32'h7FFFFFFF, 32'h80000000);
      send_counts(32'h80000000, 32'h7FFFFFFF);
      send_counts(32'hFFFFFFFF, 32'h00000000);
      send_counts(32'h00000000, 32'hFFFFFFFF);
      send_counts(32'h7FFFFFFF, 32'h7FFFFFFF);
      send_counts(32'hAAAAAAAA, 32'h55555555);
      wait_idle();
   endtask

   task automatic test_special_cases();
      // Zero divisors, then a huge turn with a large radius and saturating positions.
      write_reg(CFG_TICKS_PER_TURN, 32'd0);
      write_reg(CFG_WHEEL_BASE, 32'd0);
      write_reg(CFG_WHEEL_RADIUS, 32'hFFFF);
      write_reg(CFG_INITIAL_X, 32'h7FFF0000);
      write_reg(CFG_INITIAL_Y, 32'h80010000);
      send_move(1, 1);
      send_move(1000, -1000);
      send_counts(32'h80000000, 32'h80000000);
      wait_idle();
      write_reg(CFG_LINEAR_ADJUST, 32'h7FFFFFFF);
      write_reg(CFG_ANGULAR_ADJUST, 32'h80000000);
      send_move(5, -3);
      send_move(-7, -7);
      wait_idle();
      write_reg(CFG_LINEAR_ADJUST, 32'h80000000);
      write_reg(CFG_ANGULAR_ADJUST, 32'h7FFFFFFF);
      write_reg(CFG_WHEEL_BASE, 32'h3FFFF);
      write_reg(CFG_TICKS_PER_TURN, 32'hFFFFFFFF);
      write_reg(CFG_INITIAL_HEADING, 32'hFFFF);
      send_move(12345, -54321);
      send_move(-1, 1);
      wait_idle();
      write_reg(CFG_UNUSED_LOW, 32'hFFFFFFFF);
      write_reg(CFG_UNUSED_HIGH, 32'h12345678);
      write_reg(CFG_TICKS_PER_TURN, 32'h00010000);
      write_reg(CFG_WHEEL_RADIUS, 32'd1);
      write_reg(CFG_WHEEL_BASE, 32'd1);
      send_move(77, 33);
      send_move(-4000, 4000);
      wait_idle();
   endtask

   function automatic logic [31:0] pick_reg(input logic [CSR_IDX_W-1:0] idx);
      int sel;
      sel = $urandom_range(0, 5);
      case (idx)
         CFG_INITIAL_X, CFG_INITIAL_Y:
            return (sel == 0) ? $urandom() : 32'($signed($urandom_range(0, 2000000)) - 1000000);
         CFG_INITIAL_HEADING: return $urandom_range(0, 65535);
         CFG_LINEAR_ADJUST, CFG_ANGULAR_ADJUST:
            return (sel == 0) ? $urandom() : 32'($signed($urandom_range(0, 8000)) - 4000);
         CFG_WHEEL_RADIUS: return (sel == 0) ? 32'hFFFF : $urandom_range(1, 65535);
         CFG_WHEEL_BASE: return (sel == 0) ? 32'h3FFFF : $urandom_range(1, 262143);
         default: return (sel == 0) ? 32'h00010000 : $urandom_range(32'h10000, 32'hFFFFFFFF);
      endcase
   endfunction

   task automatic test_random_phase(input int count, input bit defaults);
      int mode;
      if (defaults) write_defaults();
      else for (int i = 0; i < 8; i++)
         write_reg(CFG_INITIAL_X + 4'(i), pick_reg(CFG_INITIAL_X + 4'(i)));
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 15);
         if (mode == 0) send_counts($urandom(), $urandom());
         else if (mode == 1) send_move(0, 0);
         else send_move($signed($urandom_range(0, 4000)) - 2000,
                        $signed($urandom_range(0, 4000)) - 2000);
      end
      wait_idle();
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (30000) @(posedge clock);
            hold_off = 1'b0;
         end
      join_none
      for (int n = 0; n < 4; n++) send_move(n * 50, -n * 40);
      wait_idle();
      send_move(500, -200);
      wait_idle();
   endtask

   // Result side: random stalls and field-by-field checking.
   initial begin
      int hold;
      pose_type want;
      hold = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (pose_q.size() == 0) begin
               mismatches++;
               $display("unexpected result transfer at cycle %0d", cycles);
            end else begin
               want = pose_q.pop_front();
               if (rsp_chan.euler_x !== want.euler_x)
                  report_mismatch("euler_x", rsp_chan.euler_x, want.euler_x);
               if (rsp_chan.euler_y !== want.euler_y)
                  report_mismatch("euler_y", rsp_chan.euler_y, want.euler_y);
               if (rsp_chan.euler_heading !== want.euler_heading)
                  report_mismatch("euler_heading", rsp_chan.euler_heading, want.euler_heading);
               if (rsp_chan.arc_x !== want.arc_x)
                  report_mismatch("arc_x", rsp_chan.arc_x, want.arc_x);
               if (rsp_chan.arc_y !== want.arc_y)
                  report_mismatch("arc_y", rsp_chan.arc_y, want.arc_y);
               if (rsp_chan.arc_heading !== want.arc_heading)
                  report_mismatch("arc_heading", rsp_chan.arc_heading, want.arc_heading);
            end
         end
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 15) == 0) begin
            hold = $urandom_range(1, 18) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.left_count <= '0;
      req_chan.right_count <= '0;
      odo_reset();
      cur_left = 0;
      cur_right = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);
      test_directed_moves();
      test_special_cases();
      test_random_phase(180, 1'b1);
      test_backpressure();
      for (int ph = 0; ph < 3; ph++) test_random_phase(180, 1'b0);
      idle_on = 1'b0;
      test_random_phase(180, 1'b0);
      wait_idle();
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
src/ddo_pkg.sv
src/ddo_req_if.sv
src/ddo_rsp_if.sv
src/ddo_muldiv.sv
src/diff_drive_odometry.sv
src/ddo_checker.sv
tb/tb.sv
